// ----- hw/rtl/gdt_pkg.sv -----
package gdt_pkg;

    // field widths
    localparam int LAT_W      = 28;
    localparam int LON_W      = 29;
    localparam int TS_W       = 32;
    localparam int RADIUS_W   = 25;
    localparam int THR_W      = 32;
    localparam int CNT_OUT_W  = 20;
    localparam int TIME_W     = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int COUNT_BITS = 20;
    localparam longint unsigned EARTH_RADIUS_M = 64'd6371000;

    // sequencing
    localparam int CORDIC_STEPS  = 30;
    localparam int ROOT_STEPS    = 31;
    localparam int ANGLE_STEPS   = 8;
    localparam int PRODUCT_STEPS = 5;
    localparam int STEP_W        = 5;

    // datapath widths
    localparam int XY_W   = 35;
    localparam int Z_W    = 34;
    localparam int Q_W    = 31;
    localparam int MUL_W  = 31;
    localparam int PROD_W = 62;
    localparam int A_W    = 61;
    localparam int ROOT_W = 62;
    localparam int DIST_W = 26;
    localparam int ULAT_W = LAT_W - 1;
    localparam int ULON_W = LON_W + 1;

    localparam logic [Q_W-1:0] CORDIC_GAIN = 31'd652032874;
    localparam logic [Q_W-1:0] ONE_Q30     = 31'd1073741824;
    localparam logic [A_W-1:0] ONE_Q60     = A_W'(1) << 60;

    // microdegrees to Q30 radians, constant split so each half fits the multiplier
    localparam logic [63:0] UDEG_TO_RAD = 64'd40244552545;
    localparam int K_SPLIT = 18;
    localparam logic [MUL_W-1:0] K_LO = MUL_W'(UDEG_TO_RAD & ((64'd1 << K_SPLIT) - 64'd1));
    localparam logic [MUL_W-1:0] K_HI = MUL_W'(UDEG_TO_RAD >> K_SPLIT);
    localparam logic [MUL_W-1:0] DIST_SCALE = MUL_W'(EARTH_RADIUS_M * 64'd2);

    localparam logic signed [LAT_W-1:0] LAT_LIMIT = 28'sd90000000;
    localparam logic [ULON_W-1:0] FULL_TURN = 30'd360000000;
    localparam logic [ULON_W-1:0] HALF_TURN = 30'd180000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTRE_LAT = 3'd0,
        CFG_CENTRE_LON = 3'd1,
        CFG_RADIUS     = 3'd2,
        CFG_RING       = 3'd3,
        CFG_THRESHOLD  = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_WRAP,
        ST_ANGLE,
        ST_ROT_LOAD,
        ST_ROTATE,
        ST_PRODUCT,
        ST_ROOT_LOAD,
        ST_ROOT,
        ST_VEC_LOAD,
        ST_VECTOR,
        ST_DIST,
        ST_UPDATE
    } state_t;

    typedef enum logic [2:0] {
        MUL_ANG_LO,
        MUL_ANG_HI,
        MUL_CC,
        MUL_T,
        MUL_P1,
        MUL_P2,
        MUL_P3,
        MUL_DIST
    } mul_sel_t;

    typedef struct packed {
        logic              load_in;
        logic              prep;
        logic              wrap;
        logic              mul_en;
        mul_sel_t          mul_sel;
        logic              rot_load;
        logic              vec_load;
        logic              cordic_step;
        logic              root_load;
        logic              root_step;
        logic              update;
        logic [STEP_W-1:0] step;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
    } dp_status_t;

    function automatic logic [Q_W-1:0] atan_q30(input logic [STEP_W-1:0] idx);
        logic [Q_W-1:0] v;
        unique case (idx)
            5'd0:  v = 31'd843314857;
            5'd1:  v = 31'd497837829;
            5'd2:  v = 31'd263043837;
            5'd3:  v = 31'd133525159;
            5'd4:  v = 31'd67021687;
            5'd5:  v = 31'd33543516;
            5'd6:  v = 31'd16775851;
            5'd7:  v = 31'd8388437;
            5'd8:  v = 31'd4194283;
            5'd9:  v = 31'd2097149;
            5'd10: v = 31'd1048576;
            5'd11: v = 31'd524288;
            5'd12: v = 31'd262144;
            5'd13: v = 31'd131072;
            5'd14: v = 31'd65536;
            5'd15: v = 31'd32768;
            5'd16: v = 31'd16384;
            5'd17: v = 31'd8192;
            5'd18: v = 31'd4096;
            5'd19: v = 31'd2048;
            5'd20: v = 31'd1024;
            5'd21: v = 31'd512;
            5'd22: v = 31'd256;
            5'd23: v = 31'd128;
            5'd24: v = 31'd64;
            5'd25: v = 31'd32;
            5'd26: v = 31'd16;
            5'd27: v = 31'd8;
            5'd28: v = 31'd4;
            5'd29: v = 31'd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/geofence_dwell_time_accumulator.sv -----
// geofence dwell-time accumulator for one circular zone
//
// input channel (s_valid/s_ready): one item per position report with
// latitude/longitude in microdegrees, a timestamp in seconds and a
// last_point flag. result channel (m_valid/m_ready): one item per track,
// issued after the item flagged last_point, carrying counts, dwell times
// in half-seconds and the entered/loiter/order flags.
// configuration (cfg_valid/cfg_ready/cfg_index/cfg_data): cfg_ready is
// always high; index 0 centre latitude, 1 centre longitude, 2 radius,
// 3 near ring width, 4 loiter threshold; other indexes are ignored.
//
// sequencing: an item is processed one at a time; s_ready is high only
// in the idle state, so it returns once the track state is updated.
// each item runs two 30-step cordic passes, 31 square-root steps and
// products on the one shared 31x31 multiplier. a result is valid the cycle
// after the last item's update and sits in an output register; the next
// item is accepted while it waits. only a last item that finds that
// register still full waits in its update step until m_ready.
// reset (aresetn, synchronous, active low) loads the default zone and
// clears the track state and any pending result.
module geofence_dwell_time_accumulator (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // position items
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [gdt_pkg::LAT_W-1:0]     s_latitude,
    input  logic signed [gdt_pkg::LON_W-1:0]     s_longitude,
    input  logic [gdt_pkg::TS_W-1:0]             s_timestamp,
    input  logic                                 s_last_point,
    // track summaries
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [gdt_pkg::CNT_OUT_W-1:0]        m_points_inside,
    output logic [gdt_pkg::CNT_OUT_W-1:0]        m_points_near,
    output logic [gdt_pkg::TIME_W-1:0]           m_time_inside,
    output logic [gdt_pkg::TIME_W-1:0]           m_time_near,
    output logic                                 m_entered,
    output logic                                 m_loiter_inside,
    output logic                                 m_loiter_near,
    output logic                                 m_order_error,
    // register writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gdt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gdt_pkg::CFG_DATA_W-1:0]       cfg_data
);

    gdt_pkg::dp_cmd_t    cmd;
    gdt_pkg::dp_status_t status;

    // registers always take a write; software is to write only between tracks, unchecked by the block
    assign cfg_ready = 1'b1;

    // sequencer: walks each item through the distance pipeline steps
    gdt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // haversine distance, classification and dwell accumulation
    gdt_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .status          (status),
        .s_latitude      (s_latitude),
        .s_longitude     (s_longitude),
        .s_timestamp     (s_timestamp),
        .s_last_point    (s_last_point),
        .cfg_write       (cfg_valid & cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_points_inside (m_points_inside),
        .m_points_near   (m_points_near),
        .m_time_inside   (m_time_inside),
        .m_time_near     (m_time_near),
        .m_entered       (m_entered),
        .m_loiter_inside (m_loiter_inside),
        .m_loiter_near   (m_loiter_near),
        .m_order_error   (m_order_error)
    );

endmodule

// ----- hw/rtl/gdt_cordic.sv -----
module gdt_cordic (
    input  logic                               aclk,
    input  logic                               load,
    input  logic                               step_en,
    input  logic                               vec_mode,
    input  logic [gdt_pkg::STEP_W-1:0]         idx,
    input  logic signed [gdt_pkg::XY_W-1:0]    x_init,
    input  logic signed [gdt_pkg::XY_W-1:0]    y_init,
    input  logic signed [gdt_pkg::Z_W-1:0]     z_init,
    output logic [gdt_pkg::Q_W-1:0]            sin_q,
    output logic [gdt_pkg::Q_W-1:0]            cos_q,
    output logic [gdt_pkg::Q_W-1:0]            angle_q
);

    logic signed [gdt_pkg::XY_W-1:0] x_reg, y_reg, x_next, y_next, xs, ys;
    logic signed [gdt_pkg::Z_W-1:0]  z_reg, z_next, at;
    logic                            dir;

    function automatic logic [gdt_pkg::Q_W-1:0] clamp_q30(
        input logic signed [gdt_pkg::XY_W-1:0] v);
        logic [gdt_pkg::Q_W-1:0] r;
        if (v[gdt_pkg::XY_W-1]) begin
            r = '0;
        end else if (v > signed'(gdt_pkg::XY_W'(gdt_pkg::ONE_Q30))) begin
            r = gdt_pkg::ONE_Q30;
        end else begin
            r = v[gdt_pkg::Q_W-1:0];
        end
        return r;
    endfunction

    always_comb begin
        xs  = x_reg >>> idx;
        ys  = y_reg >>> idx;
        at  = signed'(gdt_pkg::Z_W'(gdt_pkg::atan_q30(idx)));
        // rotate toward zero residual angle, or drive y toward zero when vectoring
        dir = vec_mode ? !(!y_reg[gdt_pkg::XY_W-1] && (y_reg != '0))
                       : !z_reg[gdt_pkg::Z_W-1];
        if (dir) begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - at;
        end else begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + at;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            x_reg <= x_init;
            y_reg <= y_init;
            z_reg <= z_init;
        end else if (step_en) begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign sin_q   = clamp_q30(y_reg);
    assign cos_q   = clamp_q30(x_reg);
    assign angle_q = z_reg[gdt_pkg::Z_W-1] ? '0 : z_reg[gdt_pkg::Q_W-1:0];

endmodule

// ----- hw/rtl/gdt_isqrt.sv -----
module gdt_isqrt (
    input  logic                      aclk,
    input  logic                      load,
    input  logic                      step_en,
    input  logic [gdt_pkg::A_W-1:0]   n_init,
    output logic [gdt_pkg::Q_W-1:0]   root
);

    logic [gdt_pkg::ROOT_W-1:0] n_reg, r_reg, bit_reg, trial;

    assign trial = r_reg + bit_reg;

    // one result bit per step, bit weight moves down two places each time
    always_ff @(posedge aclk) begin
        if (load) begin
            n_reg   <= gdt_pkg::ROOT_W'(n_init);
            r_reg   <= '0;
            bit_reg <= gdt_pkg::ROOT_W'(1) << (2 * (gdt_pkg::ROOT_STEPS - 1));
        end else if (step_en) begin
            if (n_reg >= trial) begin
                n_reg <= n_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end else begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign root = r_reg[gdt_pkg::Q_W-1:0];

endmodule

// ----- hw/rtl/gdt_datapath.sv -----
module gdt_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  gdt_pkg::dp_cmd_t                     cmd,
    output gdt_pkg::dp_status_t                  status,
    input  logic signed [gdt_pkg::LAT_W-1:0]     s_latitude,
    input  logic signed [gdt_pkg::LON_W-1:0]     s_longitude,
    input  logic [gdt_pkg::TS_W-1:0]             s_timestamp,
    input  logic                                 s_last_point,
    input  logic                                 cfg_write,
    input  logic [gdt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gdt_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic [gdt_pkg::CNT_OUT_W-1:0]        m_points_inside,
    output logic [gdt_pkg::CNT_OUT_W-1:0]        m_points_near,
    output logic [gdt_pkg::TIME_W-1:0]           m_time_inside,
    output logic [gdt_pkg::TIME_W-1:0]           m_time_near,
    output logic                                 m_entered,
    output logic                                 m_loiter_inside,
    output logic                                 m_loiter_near,
    output logic                                 m_order_error
);

    localparam int CW = gdt_pkg::COUNT_BITS;
    localparam logic [CW-1:0] COUNT_CAP = {CW{1'b1}};
    localparam logic [gdt_pkg::TIME_W-1:0] TIME_MAX = {gdt_pkg::TIME_W{1'b1}};

    // configuration
    logic signed [gdt_pkg::LAT_W-1:0]  cfg_lat_reg;
    logic signed [gdt_pkg::LON_W-1:0]  cfg_lon_reg;
    logic [gdt_pkg::RADIUS_W-1:0]      cfg_radius_reg, cfg_ring_reg;
    logic [gdt_pkg::THR_W-1:0]         cfg_thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_lat_reg    <= '0;
            cfg_lon_reg    <= '0;
            cfg_radius_reg <= gdt_pkg::RADIUS_W'(1000);
            cfg_ring_reg   <= '0;
            cfg_thr_reg    <= '0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                gdt_pkg::CFG_CENTRE_LAT: cfg_lat_reg    <= cfg_data[gdt_pkg::LAT_W-1:0];
                gdt_pkg::CFG_CENTRE_LON: cfg_lon_reg    <= cfg_data[gdt_pkg::LON_W-1:0];
                gdt_pkg::CFG_RADIUS:     cfg_radius_reg <= cfg_data[gdt_pkg::RADIUS_W-1:0];
                gdt_pkg::CFG_RING:       cfg_ring_reg   <= cfg_data[gdt_pkg::RADIUS_W-1:0];
                gdt_pkg::CFG_THRESHOLD:  cfg_thr_reg    <= cfg_data[gdt_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // item capture
    logic signed [gdt_pkg::LAT_W-1:0] lat_reg;
    logic signed [gdt_pkg::LON_W-1:0] lon_reg;
    logic [gdt_pkg::TS_W-1:0]         ts_reg;
    logic                             last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            lat_reg  <= s_latitude;
            lon_reg  <= s_longitude;
            ts_reg   <= s_timestamp;
            last_reg <= s_last_point;
        end
    end

    assign status.last = last_reg;

    // coordinate differences
    function automatic logic signed [gdt_pkg::LAT_W-1:0] clamp_lat(
        input logic signed [gdt_pkg::LAT_W-1:0] v);
        logic signed [gdt_pkg::LAT_W-1:0] r;
        if (v > gdt_pkg::LAT_LIMIT) begin
            r = gdt_pkg::LAT_LIMIT;
        end else if (v < -gdt_pkg::LAT_LIMIT) begin
            r = -gdt_pkg::LAT_LIMIT;
        end else begin
            r = v;
        end
        return r;
    endfunction

    logic signed [gdt_pkg::LAT_W-1:0]  la1, la2;
    logic signed [gdt_pkg::LAT_W:0]    dlat_s;
    logic signed [gdt_pkg::LON_W:0]    dlon_s;
    logic [gdt_pkg::LAT_W-1:0]         dlat_reg, dlon_reg;
    logic [gdt_pkg::ULAT_W-1:0]        mla1_reg, mla2_reg;
    logic [gdt_pkg::ULON_W-1:0]        dlon_raw_reg, dlon_w1;

    always_comb begin
        la1    = clamp_lat(lat_reg);
        la2    = clamp_lat(cfg_lat_reg);
        dlat_s = (gdt_pkg::LAT_W+1)'(la1) - (gdt_pkg::LAT_W+1)'(la2);
        dlon_s = (gdt_pkg::LON_W+1)'(lon_reg) - (gdt_pkg::LON_W+1)'(cfg_lon_reg);
        dlon_w1 = (dlon_raw_reg >= gdt_pkg::FULL_TURN) ? dlon_raw_reg - gdt_pkg::FULL_TURN
                                                       : dlon_raw_reg;
    end

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            dlat_reg     <= dlat_s[gdt_pkg::LAT_W] ? gdt_pkg::LAT_W'(-dlat_s)
                                                   : gdt_pkg::LAT_W'(dlat_s);
            mla1_reg     <= la1[gdt_pkg::LAT_W-1] ? gdt_pkg::ULAT_W'(-la1)
                                                  : gdt_pkg::ULAT_W'(la1);
            mla2_reg     <= la2[gdt_pkg::LAT_W-1] ? gdt_pkg::ULAT_W'(-la2)
                                                  : gdt_pkg::ULAT_W'(la2);
            dlon_raw_reg <= dlon_s[gdt_pkg::LON_W] ? gdt_pkg::ULON_W'(-dlon_s)
                                                   : gdt_pkg::ULON_W'(dlon_s);
        end
        if (cmd.wrap) begin
            dlon_reg <= (dlon_w1 > gdt_pkg::HALF_TURN)
                ? gdt_pkg::LAT_W'(gdt_pkg::FULL_TURN - dlon_w1)
                : gdt_pkg::LAT_W'(dlon_w1);
        end
    end

    // cordic lanes: 0 latitude difference (later arcsine), 1 longitude difference,
    // 2 point latitude, 3 centre latitude
    logic [gdt_pkg::Q_W-1:0] s1, s2, ca, cb, z_ang, q_root, p_root;
    logic [gdt_pkg::Q_W-1:0] ang_reg [4];
    logic                    cordic_load;
    logic signed [gdt_pkg::XY_W-1:0] gain_x;

    assign cordic_load = cmd.rot_load | cmd.vec_load;
    assign gain_x      = signed'(gdt_pkg::XY_W'(gdt_pkg::CORDIC_GAIN));

    gdt_cordic u_cordic0 (
        .aclk     (aclk),
        .load     (cordic_load),
        .step_en  (cmd.cordic_step),
        .vec_mode (cmd.vec_load | !cmd.rot_load & (cmd.mul_sel == gdt_pkg::MUL_DIST)),
        .idx      (cmd.step),
        .x_init   (cmd.vec_load ? signed'(gdt_pkg::XY_W'(p_root)) : gain_x),
        .y_init   (cmd.vec_load ? signed'(gdt_pkg::XY_W'(q_root)) : '0),
        .z_init   (cmd.vec_load ? '0 : signed'(gdt_pkg::Z_W'(ang_reg[0]))),
        .sin_q    (s1),
        .cos_q    (),
        .angle_q  (z_ang)
    );

    gdt_cordic u_cordic1 (
        .aclk     (aclk),
        .load     (cmd.rot_load),
        .step_en  (cmd.cordic_step),
        .vec_mode (1'b0),
        .idx      (cmd.step),
        .x_init   (gain_x),
        .y_init   ('0),
        .z_init   (signed'(gdt_pkg::Z_W'(ang_reg[1]))),
        .sin_q    (s2),
        .cos_q    (),
        .angle_q  ()
    );

    gdt_cordic u_cordic2 (
        .aclk     (aclk),
        .load     (cmd.rot_load),
        .step_en  (cmd.cordic_step),
        .vec_mode (1'b0),
        .idx      (cmd.step),
        .x_init   (gain_x),
        .y_init   ('0),
        .z_init   (signed'(gdt_pkg::Z_W'(ang_reg[2]))),
        .sin_q    (),
        .cos_q    (ca),
        .angle_q  ()
    );

    gdt_cordic u_cordic3 (
        .aclk     (aclk),
        .load     (cmd.rot_load),
        .step_en  (cmd.cordic_step),
        .vec_mode (1'b0),
        .idx      (cmd.step),
        .x_init   (gain_x),
        .y_init   ('0),
        .z_init   (signed'(gdt_pkg::Z_W'(ang_reg[3]))),
        .sin_q    (),
        .cos_q    (cb),
        .angle_q  ()
    );

    // shared multiplier
    logic [1:0]                   lane;
    logic [gdt_pkg::MUL_W-1:0]    mul_a, mul_b, u_sel;
    logic [gdt_pkg::PROD_W-1:0]   mul_p, tmp_reg, acc_reg;
    logic [gdt_pkg::A_W-1:0]      t_reg, a_cl;
    logic [gdt_pkg::Q_W-1:0]      cc_reg;
    logic [63:0]                  ang_full;
    logic [gdt_pkg::PROD_W:0]     dist_sum;
    logic [gdt_pkg::DIST_W-1:0]   dist_reg;

    assign lane = cmd.step[2:1];

    always_comb begin
        unique case (lane)
            2'd0: u_sel = gdt_pkg::MUL_W'(dlat_reg);
            2'd1: u_sel = gdt_pkg::MUL_W'(dlon_reg);
            2'd2: u_sel = gdt_pkg::MUL_W'(mla1_reg);
            2'd3: u_sel = gdt_pkg::MUL_W'(mla2_reg);
            default: u_sel = '0;
        endcase
        unique case (cmd.mul_sel)
            gdt_pkg::MUL_ANG_LO: begin mul_a = u_sel; mul_b = gdt_pkg::K_LO; end
            gdt_pkg::MUL_ANG_HI: begin mul_a = u_sel; mul_b = gdt_pkg::K_HI; end
            gdt_pkg::MUL_CC:     begin mul_a = ca;    mul_b = cb; end
            gdt_pkg::MUL_T:      begin mul_a = s2;    mul_b = s2; end
            gdt_pkg::MUL_P1:     begin mul_a = s1;    mul_b = s1; end
            gdt_pkg::MUL_P2: begin
                mul_a = t_reg[gdt_pkg::A_W-1:30];
                mul_b = cc_reg;
            end
            gdt_pkg::MUL_P3: begin
                mul_a = gdt_pkg::MUL_W'(t_reg[29:0]);
                mul_b = cc_reg;
            end
            gdt_pkg::MUL_DIST:   begin mul_a = z_ang; mul_b = gdt_pkg::DIST_SCALE; end
            default:             begin mul_a = '0;    mul_b = '0; end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign ang_full = (64'(mul_p) << gdt_pkg::K_SPLIT) + 64'(tmp_reg);
    assign dist_sum = (gdt_pkg::PROD_W+1)'(mul_p) + ((gdt_pkg::PROD_W+1)'(1) << 29);
    assign a_cl     = (acc_reg > gdt_pkg::PROD_W'(gdt_pkg::ONE_Q60)) ? gdt_pkg::ONE_Q60
                                                                     : acc_reg[gdt_pkg::A_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            unique case (cmd.mul_sel)
                gdt_pkg::MUL_ANG_LO: tmp_reg <= mul_p;
                gdt_pkg::MUL_ANG_HI: begin
                    // half-angle lanes drop one bit more
                    ang_reg[lane] <= lane[1] ? ang_full[61:31] : ang_full[62:32];
                end
                gdt_pkg::MUL_CC:   cc_reg   <= mul_p[60:30];
                gdt_pkg::MUL_T:    t_reg    <= mul_p[gdt_pkg::A_W-1:0];
                gdt_pkg::MUL_P1:   acc_reg  <= mul_p;
                gdt_pkg::MUL_P2:   acc_reg  <= acc_reg + mul_p;
                gdt_pkg::MUL_P3:   acc_reg  <= acc_reg + (mul_p >> 30);
                gdt_pkg::MUL_DIST: dist_reg <= dist_sum[gdt_pkg::DIST_W+29:30];
                default: ;
            endcase
        end
    end

    gdt_isqrt u_root_a (
        .aclk    (aclk),
        .load    (cmd.root_load),
        .step_en (cmd.root_step),
        .n_init  (a_cl),
        .root    (q_root)
    );

    gdt_isqrt u_root_b (
        .aclk    (aclk),
        .load    (cmd.root_load),
        .step_en (cmd.root_step),
        .n_init  (gdt_pkg::ONE_Q60 - a_cl),
        .root    (p_root)
    );

    // track state
    logic [gdt_pkg::TS_W-1:0]   prev_time_reg;
    logic                       prev_inside_reg, prev_near_reg, have_prev_reg, ts_err_reg;
    logic [CW-1:0]              in_cnt_reg, nr_cnt_reg, in_cnt_next, nr_cnt_next;
    logic [gdt_pkg::TIME_W-1:0] in_time_reg, nr_time_reg, in_time_next, nr_time_next;
    logic                       ins, nr, backwards, add_time, ts_err_next;
    logic [gdt_pkg::DIST_W-1:0] near_lim;
    logic [gdt_pkg::TS_W-1:0]   dt;
    logic [gdt_pkg::THR_W:0]    thr2;

    function automatic logic [gdt_pkg::TS_W:0] share(
        input logic p, input logic c, input logic [gdt_pkg::TS_W-1:0] d);
        logic [gdt_pkg::TS_W:0] r;
        if (p && c) begin
            r = {d, 1'b0};
        end else if (p || c) begin
            r = {1'b0, d};
        end else begin
            r = '0;
        end
        return r;
    endfunction

    function automatic logic [gdt_pkg::TIME_W-1:0] sat_add(
        input logic [gdt_pkg::TIME_W-1:0] acc, input logic [gdt_pkg::TS_W:0] v);
        logic [gdt_pkg::TIME_W:0] s;
        s = (gdt_pkg::TIME_W+1)'(acc) + (gdt_pkg::TIME_W+1)'(v);
        return s[gdt_pkg::TIME_W] ? TIME_MAX : s[gdt_pkg::TIME_W-1:0];
    endfunction

    function automatic logic [gdt_pkg::CNT_OUT_W-1:0] cap_count(input logic [CW-1:0] c);
        logic [32:0] w;
        w = 33'(c);
        return (w > 33'({gdt_pkg::CNT_OUT_W{1'b1}})) ? {gdt_pkg::CNT_OUT_W{1'b1}}
                                                     : w[gdt_pkg::CNT_OUT_W-1:0];
    endfunction

    always_comb begin
        near_lim     = gdt_pkg::DIST_W'(cfg_radius_reg) + gdt_pkg::DIST_W'(cfg_ring_reg);
        ins          = dist_reg <= gdt_pkg::DIST_W'(cfg_radius_reg);
        nr           = !ins && (dist_reg <= near_lim);
        in_cnt_next  = (ins && in_cnt_reg != COUNT_CAP) ? in_cnt_reg + CW'(1) : in_cnt_reg;
        nr_cnt_next  = (nr && nr_cnt_reg != COUNT_CAP) ? nr_cnt_reg + CW'(1) : nr_cnt_reg;
        dt           = ts_reg - prev_time_reg;
        backwards    = have_prev_reg && (ts_reg < prev_time_reg);
        add_time     = have_prev_reg && !backwards;
        ts_err_next  = ts_err_reg | backwards;
        in_time_next = add_time ? sat_add(in_time_reg, share(prev_inside_reg, ins, dt))
                                : in_time_reg;
        nr_time_next = add_time ? sat_add(nr_time_reg, share(prev_near_reg, nr, dt))
                                : nr_time_reg;
        thr2         = {cfg_thr_reg, 1'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_time_reg   <= '0;
            prev_inside_reg <= 1'b0;
            prev_near_reg   <= 1'b0;
            have_prev_reg   <= 1'b0;
            ts_err_reg      <= 1'b0;
            in_cnt_reg      <= '0;
            nr_cnt_reg      <= '0;
            in_time_reg     <= '0;
            nr_time_reg     <= '0;
        end else if (cmd.update) begin
            if (last_reg) begin
                prev_time_reg   <= '0;
                prev_inside_reg <= 1'b0;
                prev_near_reg   <= 1'b0;
                have_prev_reg   <= 1'b0;
                ts_err_reg      <= 1'b0;
                in_cnt_reg      <= '0;
                nr_cnt_reg      <= '0;
                in_time_reg     <= '0;
                nr_time_reg     <= '0;
            end else begin
                prev_time_reg   <= ts_reg;
                prev_inside_reg <= ins;
                prev_near_reg   <= nr;
                have_prev_reg   <= 1'b1;
                ts_err_reg      <= ts_err_next;
                in_cnt_reg      <= in_cnt_next;
                nr_cnt_reg      <= nr_cnt_next;
                in_time_reg     <= in_time_next;
                nr_time_reg     <= nr_time_next;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.update && last_reg) begin
            m_points_inside <= cap_count(in_cnt_next);
            m_points_near   <= cap_count(nr_cnt_next);
            m_time_inside   <= in_time_next;
            m_time_near     <= nr_time_next;
            m_entered       <= in_cnt_next != '0;
            m_loiter_inside <= in_time_next >= gdt_pkg::TIME_W'(thr2);
            m_loiter_near   <= nr_time_next >= gdt_pkg::TIME_W'(thr2);
            m_order_error   <= ts_err_next;
        end
    end

endmodule

// ----- hw/rtl/gdt_ctrl.sv -----
module gdt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  gdt_pkg::dp_status_t  status,
    output gdt_pkg::dp_cmd_t     cmd
);

    gdt_pkg::state_t             state_reg, state_next;
    logic [gdt_pkg::STEP_W-1:0]  step_reg, step_next;
    logic                        m_valid_reg, m_valid_next;
    logic                        fire, counting;

    assign fire = (state_reg == gdt_pkg::ST_UPDATE)
                  && (!status.last || !m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            gdt_pkg::ST_IDLE:      if (s_valid) state_next = gdt_pkg::ST_PREP;
            gdt_pkg::ST_PREP:      state_next = gdt_pkg::ST_WRAP;
            gdt_pkg::ST_WRAP:      state_next = gdt_pkg::ST_ANGLE;
            gdt_pkg::ST_ANGLE:
                if (step_reg == gdt_pkg::STEP_W'(gdt_pkg::ANGLE_STEPS - 1))
                    state_next = gdt_pkg::ST_ROT_LOAD;
            gdt_pkg::ST_ROT_LOAD:  state_next = gdt_pkg::ST_ROTATE;
            gdt_pkg::ST_ROTATE:
                if (step_reg == gdt_pkg::STEP_W'(gdt_pkg::CORDIC_STEPS - 1))
                    state_next = gdt_pkg::ST_PRODUCT;
            gdt_pkg::ST_PRODUCT:
                if (step_reg == gdt_pkg::STEP_W'(gdt_pkg::PRODUCT_STEPS - 1))
                    state_next = gdt_pkg::ST_ROOT_LOAD;
            gdt_pkg::ST_ROOT_LOAD: state_next = gdt_pkg::ST_ROOT;
            gdt_pkg::ST_ROOT:
                if (step_reg == gdt_pkg::STEP_W'(gdt_pkg::ROOT_STEPS - 1))
                    state_next = gdt_pkg::ST_VEC_LOAD;
            gdt_pkg::ST_VEC_LOAD:  state_next = gdt_pkg::ST_VECTOR;
            gdt_pkg::ST_VECTOR:
                if (step_reg == gdt_pkg::STEP_W'(gdt_pkg::CORDIC_STEPS - 1))
                    state_next = gdt_pkg::ST_DIST;
            gdt_pkg::ST_DIST:      state_next = gdt_pkg::ST_UPDATE;
            gdt_pkg::ST_UPDATE:    if (fire) state_next = gdt_pkg::ST_IDLE;
            default:               state_next = gdt_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        counting = (state_reg == gdt_pkg::ST_ANGLE) || (state_reg == gdt_pkg::ST_ROTATE)
                || (state_reg == gdt_pkg::ST_PRODUCT) || (state_reg == gdt_pkg::ST_ROOT)
                || (state_reg == gdt_pkg::ST_VECTOR);
        step_next = (counting && state_next == state_reg) ? step_reg + gdt_pkg::STEP_W'(1)
                                                          : '0;
        m_valid_next = m_valid_reg && !m_ready;
        if (fire && status.last) begin
            m_valid_next = 1'b1;
        end
    end

    always_comb begin
        cmd         = '0;
        cmd.mul_sel = gdt_pkg::MUL_ANG_LO;
        cmd.step    = step_reg;
        unique case (state_reg)
            gdt_pkg::ST_IDLE:      cmd.load_in = s_valid;
            gdt_pkg::ST_PREP:      cmd.prep = 1'b1;
            gdt_pkg::ST_WRAP:      cmd.wrap = 1'b1;
            gdt_pkg::ST_ANGLE: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = step_reg[0] ? gdt_pkg::MUL_ANG_HI : gdt_pkg::MUL_ANG_LO;
            end
            gdt_pkg::ST_ROT_LOAD:  cmd.rot_load = 1'b1;
            gdt_pkg::ST_ROTATE:    cmd.cordic_step = 1'b1;
            gdt_pkg::ST_PRODUCT: begin
                cmd.mul_en = 1'b1;
                unique case (step_reg)
                    5'd0:    cmd.mul_sel = gdt_pkg::MUL_CC;
                    5'd1:    cmd.mul_sel = gdt_pkg::MUL_T;
                    5'd2:    cmd.mul_sel = gdt_pkg::MUL_P1;
                    5'd3:    cmd.mul_sel = gdt_pkg::MUL_P2;
                    default: cmd.mul_sel = gdt_pkg::MUL_P3;
                endcase
            end
            gdt_pkg::ST_ROOT_LOAD: cmd.root_load = 1'b1;
            gdt_pkg::ST_ROOT:      cmd.root_step = 1'b1;
            gdt_pkg::ST_VEC_LOAD:  cmd.vec_load = 1'b1;
            gdt_pkg::ST_VECTOR: begin
                cmd.cordic_step = 1'b1;
                cmd.mul_sel     = gdt_pkg::MUL_DIST;
            end
            gdt_pkg::ST_DIST: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = gdt_pkg::MUL_DIST;
            end
            gdt_pkg::ST_UPDATE:    cmd.update = fire;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= gdt_pkg::ST_IDLE;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == gdt_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while one is in work");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= gdt_pkg::STEP_W'(gdt_pkg::ROOT_STEPS - 1))
        else $error("step counter past longest loop");

    a_hold_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gdt_pkg::ST_UPDATE) && !fire |=> state_reg == gdt_pkg::ST_UPDATE)
        else $error("update left without committing");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == gdt_pkg::ST_UPDATE))
        else $error("result raised outside update");

endmodule
